### rtl/core/hmtp_pkg.sv
// ----------------------------------------------------------------------------
// hmtp_pkg
// Shared types and constants of the height-map token parser.
// ----------------------------------------------------------------------------
package hmtp_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;

  localparam int COL_W      = 11;
  localparam int OUT_TDATA_W = 88;

  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_SIGN    = 3'd1;
  localparam logic [2:0] PH_DIGITS  = 3'd2;
  localparam logic [2:0] PH_COMMA   = 3'd3;
  localparam logic [2:0] PH_ZERO    = 3'd4;
  localparam logic [2:0] PH_HEX     = 3'd5;
  localparam logic [2:0] PH_HALT    = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_MISMATCH = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [31:0] COLOR_DEFAULT = 32'h00FF_FFFF;
  localparam logic [3:0]  DIGIT_LIMIT   = 4'd11;
  localparam logic [3:0]  DIGIT_SAT     = 4'd15;
  localparam logic [33:0] TWO31         = 34'h0_8000_0000;

  typedef struct packed {
    logic signed [31:0] height;
    logic [31:0]        color;
    logic [COL_W-1:0]   column;
    logic               token_valid;
    logic               row_done;
    logic [COL_W-1:0]   row_width;
    logic [1:0]         error;
  } result_t;

endpackage

### rtl/core/hmtp_parse_core.sv
// ----------------------------------------------------------------------------
// hmtp_parse_core
// Token state machine: one character or end-of-line per step, at most one
// result per step.
// ----------------------------------------------------------------------------
module hmtp_parse_core #(
  parameter int MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              eol,
  output logic              res_valid,
  output hmtp_pkg::result_t res
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [2:0]    phase,        phase_next;
  logic [33:0]   height_acc,   height_acc_next;
  logic          negative,     negative_next;
  logic [3:0]    digit_count,  digit_count_next;
  logic [31:0]   color_acc,    color_acc_next;
  logic          has_color,    has_color_next;
  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] first_width,  first_width_next;

  logic [1:0]     fail_code;
  logic           is_digit;
  logic [3:0]     digit;
  logic [4:0]     hex_val;
  logic [35:0]    acc_ten;
  logic [33:0]    lim;
  logic           tok_ovf;
  logic           col_full;
  logic           in_token;
  logic [CW-1:0]  n_cols;
  logic [CW+10:0] col_ext;
  logic [CW+10:0] n_ext;
  logic [31:0]    tok_height;
  logic [31:0]    tok_color;

  assign is_digit = (ch >= hmtp_pkg::CH_ZERO) && (ch <= hmtp_pkg::CH_NINE);
  assign digit    = 4'(ch - hmtp_pkg::CH_ZERO);

  always_comb begin
    if (is_digit) begin
      hex_val = {1'b0, digit};
    end else if ((ch >= hmtp_pkg::CH_LA) && (ch <= hmtp_pkg::CH_LF)) begin
      hex_val = 5'(ch - hmtp_pkg::CH_LA + 8'd10);
    end else if ((ch >= hmtp_pkg::CH_UA) && (ch <= hmtp_pkg::CH_UF)) begin
      hex_val = 5'(ch - hmtp_pkg::CH_UA + 8'd10);
    end else begin
      hex_val = 5'h10;
    end
  end

  assign acc_ten = ({2'b00, height_acc} << 3) + ({2'b00, height_acc} << 1) + {32'd0, digit};

  assign lim        = negative ? hmtp_pkg::TWO31 : (hmtp_pkg::TWO31 - 34'd1);
  assign tok_ovf    = (digit_count > hmtp_pkg::DIGIT_LIMIT) || (height_acc > lim);
  assign col_full   = column_count >= CW'(MAX_COLUMNS);
  assign in_token   = phase != hmtp_pkg::PH_BETWEEN;
  assign n_cols     = column_count + CW'(in_token);
  assign col_ext    = {11'd0, column_count};
  assign n_ext      = {11'd0, n_cols};
  assign tok_height = negative ? (32'd0 - height_acc[31:0]) : height_acc[31:0];
  assign tok_color  = has_color ? color_acc : hmtp_pkg::COLOR_DEFAULT;

  always_comb begin
    phase_next        = phase;
    height_acc_next   = height_acc;
    negative_next     = negative;
    digit_count_next  = digit_count;
    color_acc_next    = color_acc;
    has_color_next    = has_color;
    column_count_next = column_count;
    first_width_next  = first_width;
    fail_code         = hmtp_pkg::ERR_NONE;
    res               = '0;
    res_valid         = 1'b0;

    if (step && (phase != hmtp_pkg::PH_HALT)) begin
      if (eol) begin
        if ((phase == hmtp_pkg::PH_COMMA) || (phase == hmtp_pkg::PH_ZERO)) begin
          fail_code = hmtp_pkg::ERR_BAD_CHAR;
        end else if (in_token && col_full) begin
          fail_code = hmtp_pkg::ERR_MISMATCH;
        end else if (in_token && tok_ovf) begin
          fail_code = hmtp_pkg::ERR_OVERFLOW;
        end else if ((first_width != '0) && (n_cols != first_width)) begin
          fail_code = hmtp_pkg::ERR_MISMATCH;
        end else begin
          res_valid = 1'b1;
          if (in_token) begin
            res.height      = tok_height;
            res.color       = tok_color;
            res.column      = col_ext[10:0];
            res.token_valid = 1'b1;
          end
          res.row_done      = 1'b1;
          res.row_width     = n_ext[10:0];
          first_width_next  = n_cols;
          column_count_next = '0;
          phase_next        = hmtp_pkg::PH_BETWEEN;
          height_acc_next   = '0;
          negative_next     = 1'b0;
          digit_count_next  = '0;
          color_acc_next    = '0;
          has_color_next    = 1'b0;
        end
      end else if (ch == hmtp_pkg::CH_SPACE) begin
        if (!in_token) begin
          res_valid = 1'b0;
        end else if ((phase == hmtp_pkg::PH_COMMA) || (phase == hmtp_pkg::PH_ZERO)) begin
          fail_code = hmtp_pkg::ERR_BAD_CHAR;
        end else if (col_full) begin
          fail_code = hmtp_pkg::ERR_MISMATCH;
        end else if (tok_ovf) begin
          fail_code = hmtp_pkg::ERR_OVERFLOW;
        end else begin
          res_valid         = 1'b1;
          res.height        = tok_height;
          res.color         = tok_color;
          res.column        = col_ext[10:0];
          res.token_valid   = 1'b1;
          column_count_next = column_count + CW'(1);
          phase_next        = hmtp_pkg::PH_BETWEEN;
          height_acc_next   = '0;
          negative_next     = 1'b0;
          digit_count_next  = '0;
          color_acc_next    = '0;
          has_color_next    = 1'b0;
        end
      end else begin
        unique case (phase)
          hmtp_pkg::PH_BETWEEN, hmtp_pkg::PH_SIGN, hmtp_pkg::PH_DIGITS: begin
            if ((phase == hmtp_pkg::PH_BETWEEN) &&
                ((ch == hmtp_pkg::CH_PLUS) || (ch == hmtp_pkg::CH_MINUS))) begin
              negative_next = (ch == hmtp_pkg::CH_MINUS);
              phase_next    = hmtp_pkg::PH_SIGN;
            end else if (is_digit) begin
              if (((digit_count != '0) || (digit != '0)) &&
                  (digit_count < hmtp_pkg::DIGIT_SAT)) begin
                digit_count_next = digit_count + 4'd1;
              end
              if (acc_ten > {2'b00, hmtp_pkg::TWO31}) begin
                height_acc_next = hmtp_pkg::TWO31 + 34'd1;
              end else begin
                height_acc_next = acc_ten[33:0];
              end
              phase_next = hmtp_pkg::PH_DIGITS;
            end else if (ch == hmtp_pkg::CH_COMMA) begin
              phase_next = hmtp_pkg::PH_COMMA;
            end else begin
              fail_code = hmtp_pkg::ERR_BAD_CHAR;
            end
          end
          hmtp_pkg::PH_COMMA: begin
            if (ch == hmtp_pkg::CH_ZERO) begin
              phase_next = hmtp_pkg::PH_ZERO;
            end else begin
              fail_code = hmtp_pkg::ERR_BAD_CHAR;
            end
          end
          hmtp_pkg::PH_ZERO: begin
            if (ch == hmtp_pkg::CH_X) begin
              has_color_next = 1'b1;
              color_acc_next = '0;
              phase_next     = hmtp_pkg::PH_HEX;
            end else begin
              fail_code = hmtp_pkg::ERR_BAD_CHAR;
            end
          end
          hmtp_pkg::PH_HEX: begin
            if (!hex_val[4]) begin
              color_acc_next = {color_acc[27:0], hex_val[3:0]};
            end else begin
              fail_code = hmtp_pkg::ERR_BAD_CHAR;
            end
          end
          default: begin
            fail_code = hmtp_pkg::ERR_BAD_CHAR;
          end
        endcase
      end

      if (fail_code != hmtp_pkg::ERR_NONE) begin
        res        = '0;
        res.error  = fail_code;
        res_valid  = 1'b1;
        phase_next = hmtp_pkg::PH_HALT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hmtp_pkg::PH_BETWEEN;
      height_acc   <= '0;
      negative     <= 1'b0;
      digit_count  <= '0;
      color_acc    <= '0;
      has_color    <= 1'b0;
      column_count <= '0;
      first_width  <= '0;
    end else begin
      phase        <= phase_next;
      height_acc   <= height_acc_next;
      negative     <= negative_next;
      digit_count  <= digit_count_next;
      color_acc    <= color_acc_next;
      has_color    <= has_color_next;
      column_count <= column_count_next;
      first_width  <= first_width_next;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == hmtp_pkg::PH_HALT) |-> !res_valid)
    else $error("result produced after halt");

  a_fail_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.error != hmtp_pkg::ERR_NONE)) |=> (phase == hmtp_pkg::PH_HALT))
    else $error("error result without halt");

  a_token_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.token_valid) |-> (res.error == hmtp_pkg::ERR_NONE))
    else $error("token result carries an error");

  a_no_step_no_result: assert property (@(posedge clk) disable iff (rst)
    !step |-> !res_valid)
    else $error("result without a step");

endmodule

### rtl/core/hmtp_out_fifo.sv
// ----------------------------------------------------------------------------
// hmtp_out_fifo
// Two-entry result buffer: holds results while the output side stalls.
// ----------------------------------------------------------------------------
module hmtp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hmtp_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output hmtp_pkg::result_t out_data
);

  hmtp_pkg::result_t entry [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room      = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("buffer count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push into full buffer");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("pop did not drain an entry");

endmodule

### rtl/core/height_map_token_parser.sv
// ----------------------------------------------------------------------------
// height_map_token_parser
// Parses height-map text, one character per transaction, into tokens of
// height and color, with row closing and latched error reporting.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tlast        tuser
//  s_axis    in   ch[7:0]                     end_of_line  -
//  m_axis    out  height, color, column,      row_done     token_valid
//                 row_width, error
//
//  One input transaction per cycle while the result buffer has room; a result
//  passes through the input register, then the result buffer, on its way out.
//  The per-character state update is one short step of the parse logic.
//  rst is synchronous; it clears the parser state and empties the buffer.
//  Output stalls are absorbed by a two-entry result buffer; input stalls
//  only when both entries are full and the input register holds an item.
// ----------------------------------------------------------------------------
module height_map_token_parser #(
  parameter int MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // height[31:0], color[63:32], column[74:64], row_width[85:75],
  // error[87:86]
  output logic [hmtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // token_valid
);

  logic              in_valid;
  logic [7:0]        in_ch;
  logic              in_eol;
  logic              advance;
  logic              room;
  logic              res_valid;
  hmtp_pkg::result_t res;
  hmtp_pkg::result_t out_res;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch  <= s_axis_tdata;
      in_eol <= s_axis_tlast;
    end
  end

  hmtp_parse_core #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .ch       (in_ch),
    .eol      (in_eol),
    .res_valid(res_valid),
    .res      (res)
  );

  hmtp_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign m_axis_tdata = {out_res.error, out_res.row_width, out_res.column,
                         out_res.color, out_res.height};
  assign m_axis_tlast = out_res.row_done;
  assign m_axis_tuser = out_res.token_valid;

endmodule
